@@ sv/rsmq_pkg.sv @@
package rsmq_pkg;

  localparam int unsigned MAX_COEFFS = 256;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned COEF_W = 13;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [11:0] Q_SMALL = 12'd3329;
  localparam logic [12:0] Q_LARGE = 13'd7681;
  localparam logic [15:0] LEMIRE_THRESHOLD = 16'(32'h10000 % 32'd7681);
  localparam logic [11:0] MASK12 = 12'hFFF;

  localparam logic MODE_Q3329 = 1'b0;
  localparam logic MODE_Q7681 = 1'b1;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  localparam logic [CNT_W-1:0] TARGET_RESET = 9'd256;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_TWO
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_poly;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              last_coefficient;
  } out_t;

  typedef struct packed {
    logic two;
    out_t first;
    out_t second;
  } entry_t;

endpackage

@@ sv/rsmq_front.sv @@
module rsmq_front #(
  parameter int unsigned MaxCoeffs = rsmq_pkg::MAX_COEFFS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       mode_i,
  input  logic [rsmq_pkg::CNT_W-1:0] target_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rsmq_pkg::in_t              in_data_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output rsmq_pkg::entry_t           push_data_o
);

  localparam logic [rsmq_pkg::CNT_W-1:0] MaxTarget = rsmq_pkg::CNT_W'(MaxCoeffs);

  rsmq_pkg::phase_e phase_q, phase_d, phase0;
  logic [7:0] held0_q, held0_d, held1_q, held1_d;
  logic [rsmq_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt0, cnt_a, eff_t;

  logic        active, accept;
  logic [11:0] v0, v1;
  logic        keep0, keep1, keep_l;
  logic [28:0] prod;
  logic        cand_a, cand_b, b_ok;
  logic [rsmq_pkg::COEF_W-1:0] va, vb;
  logic        last_a, last_b;

  assign eff_t = (target_i > MaxTarget) ? MaxTarget : target_i;
  assign accept = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  assign v0 = {held1_q[3:0], held0_q} & rsmq_pkg::MASK12;
  assign v1 = {in_data_i.data_byte, held1_q[7:4]} & rsmq_pkg::MASK12;
  assign keep0 = v0 < rsmq_pkg::Q_SMALL;
  assign keep1 = v1 < rsmq_pkg::Q_SMALL;
  assign prod = 29'({in_data_i.data_byte, held0_q}) * 29'(rsmq_pkg::Q_LARGE);
  assign keep_l = prod[15:0] >= rsmq_pkg::LEMIRE_THRESHOLD;

  always_comb begin
    cnt0    = in_data_i.new_poly ? '0 : cnt_q;
    phase0  = in_data_i.new_poly ? rsmq_pkg::PH_EMPTY : phase_q;
    active  = cnt0 < eff_t;
    phase_d = phase0;
    held0_d = held0_q;
    held1_d = held1_q;
    cand_a  = 1'b0;
    cand_b  = 1'b0;
    va      = '0;
    vb      = '0;
    if (active) begin
      if (mode_i == rsmq_pkg::MODE_Q3329) begin
        case (phase0)
          rsmq_pkg::PH_EMPTY: begin
            held0_d = in_data_i.data_byte;
            phase_d = rsmq_pkg::PH_ONE;
          end
          rsmq_pkg::PH_ONE: begin
            held1_d = in_data_i.data_byte;
            phase_d = rsmq_pkg::PH_TWO;
          end
          default: begin
            phase_d = rsmq_pkg::PH_EMPTY;
            cand_a  = keep0;
            va      = rsmq_pkg::COEF_W'(v0);
            cand_b  = keep1;
            vb      = rsmq_pkg::COEF_W'(v1);
          end
        endcase
      end else begin
        if (phase0 == rsmq_pkg::PH_EMPTY) begin
          held0_d = in_data_i.data_byte;
          phase_d = rsmq_pkg::PH_ONE;
        end else begin
          phase_d = rsmq_pkg::PH_EMPTY;
          cand_a  = keep_l;
          va      = prod[28:16];
        end
      end
    end
    if (in_data_i.block_end) begin
      phase_d = rsmq_pkg::PH_EMPTY;
    end
    cnt_a  = cnt0 + rsmq_pkg::CNT_W'(cand_a);
    b_ok   = cand_b && (cnt_a < eff_t);
    cnt_d  = cnt_a + rsmq_pkg::CNT_W'(b_ok);
    last_a = cnt_a == eff_t;
    last_b = cnt_d == eff_t;
  end

  always_comb begin
    if (cand_a) begin
      push_data_o.first  = '{coefficient: va, last_coefficient: last_a};
      push_data_o.second = '{coefficient: vb, last_coefficient: last_b};
      push_data_o.two    = b_ok;
    end else begin
      push_data_o.first  = '{coefficient: vb, last_coefficient: last_b};
      push_data_o.second = '{coefficient: vb, last_coefficient: last_b};
      push_data_o.two    = 1'b0;
    end
    push_valid_o = accept && (cand_a || b_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rsmq_pkg::PH_EMPTY;
      cnt_q   <= '0;
      held0_q <= '0;
      held1_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

@@ sv/rsmq_fifo.sv @@
module rsmq_fifo #(
  parameter int unsigned Depth = rsmq_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  rsmq_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output rsmq_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full = CntW'(Depth);

  rsmq_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = cnt_q != Full;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/rsmq_back.sv @@
module rsmq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  rsmq_pkg::entry_t pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsmq_pkg::out_t   out_data_o
);

  logic           ovalid_q, ovalid_d, sec_v_q, sec_v_d, load;
  rsmq_pkg::out_t out_q, out_d, sec_q, sec_d;

  assign load        = !ovalid_q || out_ready_i;
  assign pop_ready_o = load && !sec_v_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ovalid_d = ovalid_q;
    out_d    = out_q;
    sec_v_d  = sec_v_q;
    sec_d    = sec_q;
    if (load) begin
      if (sec_v_q) begin
        out_d    = sec_q;
        ovalid_d = 1'b1;
        sec_v_d  = 1'b0;
      end else if (pop_valid_i) begin
        out_d    = pop_data_i.first;
        ovalid_d = 1'b1;
        sec_v_d  = pop_data_i.two;
        sec_d    = pop_data_i.second;
      end else begin
        ovalid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      sec_v_q  <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      sec_v_q  <= sec_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

endmodule

@@ sv/rejection_sampler_mod_q.sv @@
// Uniform rejection sampler modulo q, fed one pseudorandom byte per transfer.
// The input channel (in_valid_i, in_ready_o, in_data_i) takes a byte with its
// new_poly and block_end flags; the output channel (out_valid_o, out_ready_i,
// out_data_o) returns accepted coefficients, the one that reaches the target
// marked with last_coefficient. The APB port sets the modulus mode (address 0)
// and the target count (address 4); write them only while the block is idle.
// A byte is taken every cycle while the four-entry queue between the
// classifying front end and the output stage has room. The front end decides
// each byte in the cycle of its transfer; a coefficient that it keeps is written
// into the queue and from there into the output register. The output stage
// sends one coefficient per cycle while out_ready_i is high, so a byte group
// that yields two coefficients is sent as two transfers, the second held back.
// When the receiver stalls, the output register holds its coefficient, the
// queue fills, and in_ready_o drops once the queue is full.
// Reset clears the byte phase, the held bytes, the coefficient count and the
// queue, and sets the mode to q = 3329 and the target count to 256.
module rejection_sampler_mod_q #(
  parameter int unsigned MaxCoeffs = rsmq_pkg::MAX_COEFFS,
  parameter int unsigned FifoDepth = rsmq_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rsmq_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rsmq_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsmq_pkg::ADDR_W-1:0] paddr,
  input  logic [rsmq_pkg::DATA_W-1:0] pwdata,
  output logic [rsmq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic                       mode_q;
  logic [rsmq_pkg::CNT_W-1:0] target_q;
  logic                       wr_en;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  rsmq_pkg::entry_t push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rsmq_pkg::MODE_Q3329;
      target_q <= rsmq_pkg::TARGET_RESET;
    end else if (wr_en) begin
      if (paddr[2] == rsmq_pkg::REG_MODE) begin
        mode_q <= pwdata[0];
      end else begin
        target_q <= pwdata[rsmq_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rsmq_pkg::REG_TARGET) begin
      prdata = rsmq_pkg::DATA_W'(target_q);
    end else begin
      prdata = rsmq_pkg::DATA_W'(mode_q);
    end
  end

  rsmq_front #(
    .MaxCoeffs(MaxCoeffs)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .target_i    (target_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  rsmq_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  rsmq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ test/rejection_sampler_mod_q_tb.sv @@
`timescale 1ns / 100ps

module rejection_sampler_mod_q_tb;
  import rsmq_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  in_t                 pending_bytes[$];
  out_t                coef_due[$];
  int unsigned         errors = 0;
  int unsigned         send_gap = 0;
  int unsigned         sink_gap = 0;
  bit                  calm = 1'b0;
  bit                  hold_start = 1'b0;
  logic                hold_off = 1'b0;

  logic                mode_cfg = MODE_Q3329;
  logic [CNT_W-1:0]    target_cfg = TARGET_RESET;
  phase_e              group_phase = PH_EMPTY;
  logic [7:0]          held_lo = '0;
  logic [7:0]          held_hi = '0;
  logic [CNT_W-1:0]    coef_count = '0;

  rejection_sampler_mod_q uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic void emit_coef(logic [COEF_W-1:0] value, logic [CNT_W-1:0] goal);
    out_t c;
    if (coef_count >= goal) return;
    coef_count = coef_count + 1'b1;
    c.coefficient = value;
    c.last_coefficient = (coef_count == goal);
    coef_due.push_back(c);
  endfunction

  function automatic void predict_coefs(in_t item);
    logic [CNT_W-1:0] goal;
    logic [11:0]      v0;
    logic [11:0]      v1;
    logic [31:0]      prod;
    goal = (target_cfg > CNT_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS) : target_cfg;
    if (item.new_poly) begin
      coef_count = '0;
      group_phase = PH_EMPTY;
    end
    if (coef_count < goal) begin
      if (group_phase == PH_EMPTY) begin
        held_lo = item.data_byte;
        group_phase = PH_ONE;
      end else if (mode_cfg == MODE_Q3329 && group_phase == PH_ONE) begin
        held_hi = item.data_byte;
        group_phase = PH_TWO;
      end else if (mode_cfg == MODE_Q3329) begin
        v0 = {held_hi[3:0], held_lo};
        v1 = {item.data_byte, held_hi[7:4]};
        group_phase = PH_EMPTY;
        if (v0 < Q_SMALL) emit_coef(COEF_W'(v0), goal);
        if (v1 < Q_SMALL) emit_coef(COEF_W'(v1), goal);
      end else begin
        prod = {16'h0000, item.data_byte, held_lo} * 32'(Q_LARGE);
        group_phase = PH_EMPTY;
        if (prod[15:0] >= LEMIRE_THRESHOLD) emit_coef(prod[16 +: COEF_W], goal);
      end
    end
    if (item.block_end) group_phase = PH_EMPTY;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_coefs(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_bytes.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_coefs
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (coef_due.size() == 0) begin
          errors++;
          $error("coefficient %0d transferred with none expected", out_data_o.coefficient);
        end else begin
          want = coef_due.pop_front();
          if (out_data_o.coefficient !== want.coefficient) begin
            errors++;
            $error("coefficient: expected %0d, got %0d", want.coefficient,
                   out_data_o.coefficient);
          end
          if (out_data_o.last_coefficient !== want.last_coefficient) begin
            errors++;
            $error("last_coefficient: expected %0b, got %0b", want.last_coefficient,
                   out_data_o.last_coefficient);
          end
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic push_byte(logic [7:0] data, logic np, logic be);
    in_t item;
    item.data_byte = data;
    item.new_poly = np;
    item.block_end = be;
    pending_bytes.push_back(item);
  endtask

  task automatic apb_write(logic idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODE) mode_cfg = value[0];
    else target_cfg = value[CNT_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic settle();
    int unsigned guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || in_valid_i || coef_due.size() != 0)
           && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    if (coef_due.size() != 0) begin
      errors++;
      $error("%0d expected coefficients never arrived", coef_due.size());
      coef_due.delete();
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic push_stream(int unsigned count, int unsigned restart_odds);
    int unsigned group_len;
    int unsigned block_len;
    int unsigned sent;
    logic        np;
    logic        be;
    group_len = (mode_cfg == MODE_Q7681) ? 2 : 3;
    sent = 0;
    while (sent < count) begin
      block_len = group_len * $urandom_range(1, 8);
      for (int unsigned k = 0; k < block_len && sent < count; k++) begin
        np = (sent == 0);
        be = (k == block_len - 1);
        if (restart_odds != 0) begin
          if (k == 0 && $urandom_range(1, restart_odds) == 1) np = 1'b1;
          if ($urandom_range(0, 29) == 0) np = 1'b1;
          if ($urandom_range(0, 29) == 0) be = 1'b1;
        end
        push_byte(8'($urandom), np, be);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h0D, 1'b0, 1'b0);
    push_byte(8'hD0, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h0D, 1'b0, 1'b0);
    push_byte(8'hD0, 1'b0, 1'b0);
    push_byte(8'h12, 1'b0, 1'b0);
    push_byte(8'h34, 1'b0, 1'b1);
    push_byte(8'h56, 1'b0, 1'b0);
    push_byte(8'h78, 1'b1, 1'b0);
    push_byte(8'hAB, 1'b0, 1'b0);
    settle();
    apb_write(REG_MODE, DATA_W'(MODE_Q7681));
    push_byte(8'hCD, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    settle();
    apb_write(REG_MODE, DATA_W'(MODE_Q3329));
    apb_write(REG_TARGET, 32'd1);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h10, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    settle();

    apb_write(REG_TARGET, 32'd511);
    hold_start = 1'b1;
    push_stream(510, 0);
    settle();

    apb_write(REG_MODE, DATA_W'(MODE_Q7681));
    apb_write(REG_TARGET, 32'd256);
    push_stream(60, 3);
    settle();

    apb_write(REG_MODE, DATA_W'(MODE_Q3329));
    apb_write(REG_TARGET, 32'd0);
    push_stream(20, 3);
    settle();

    apb_write(REG_MODE, DATA_W'(MODE_Q7681));
    apb_write(REG_TARGET, 32'd1);
    push_stream(40, 2);
    settle();

    apb_write(REG_MODE, DATA_W'(MODE_Q3329));
    apb_write(REG_TARGET, 32'd300);
    push_stream(50, 3);
    settle();

    calm = 1'b1;
    apb_write(REG_MODE, DATA_W'(MODE_Q7681));
    apb_write(REG_TARGET, 32'd13);
    push_stream(60, 3);
    settle();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rsmq_pkg.sv
sv/rsmq_front.sv
sv/rsmq_fifo.sv
sv/rsmq_back.sv
sv/rejection_sampler_mod_q.sv
test/rejection_sampler_mod_q_tb.sv
